// ===== src/sat_pkg.sv =====
// Shared constants, types and helper functions of the spawn admission throttle.
`default_nettype none
package sat_pkg;

   localparam int BACKLOG_DEPTH = 64;
   localparam int TAG_BITS      = 16;
   localparam int COUNT_BITS    = 16;
   localparam int CAP_BITS      = 16;

   localparam int IDX_BITS  = $clog2(BACKLOG_DEPTH);
   localparam int FILL_BITS = $clog2(BACKLOG_DEPTH + 1);
   localparam int CMP_BITS  = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   // request tdata: from_own_worker, spawn_tag
   localparam int REQ_FIELD_BITS = 1 + TAG_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // response tdata bit positions, lowest field first
   localparam int RSP_DV_POS    = 0;
   localparam int RSP_TAG_LSB   = 1;
   localparam int RSP_DEF_POS   = RSP_TAG_LSB + TAG_BITS;
   localparam int RSP_ERR_LSB   = RSP_DEF_POS + 1;
   localparam int RSP_LIVE_LSB  = RSP_ERR_LSB + 2;
   localparam int RSP_RES_LSB   = RSP_LIVE_LSB + COUNT_BITS;
   localparam int RSP_FILL_LSB  = RSP_RES_LSB + COUNT_BITS;
   localparam int RSP_DRN_POS   = RSP_FILL_LSB + FILL_BITS;
   localparam int RSP_FIELD_BITS = RSP_DRN_POS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic {
      REQ_SPAWN    = 1'b0,
      REQ_COMPLETE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ERR_OK            = 2'd0,
      ERR_BACKLOG_FULL  = 2'd1,
      ERR_LIVE_OVERFLOW = 2'd2,
      ERR_NO_LIVE       = 2'd3
   } err_code_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [FILL_BITS-1:0]  fill_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

   localparam count_type COUNT_MAX = '1;

   function automatic idx_type next_idx(input idx_type idx);
      next_idx = (idx == IDX_BITS'(BACKLOG_DEPTH - 1)) ? '0 : idx + IDX_BITS'(1);
   endfunction

endpackage
`default_nettype wire

// ===== src/sat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/spawn_admission_throttle_unit.sv =====
// Top level of the spawn admission throttle: counters, backlog control and result register.
//
// Usage
//  - req_ channel: one transaction per event. req_tuser is the request kind
//    (0 spawn, 1 completion); req_tdata carries from_own_worker and the tag.
//  - rsp_ channel: exactly one result transaction per request, in order.
//  - csr_: resident_cap, written on any edge with csr_wr_en high; the user must write it
//    only while the block is idle (not enforced). Zero leaves the resident count uncapped.
// Throughput
//  - A result is registered at the edge that takes its request; one request
//    per cycle is sustained while rsp_tready is high: the whole event is
//    decided by short logic on the counters, and the backlog RAM read is
//    launched at the accept edge so the popped tag lands beside the result.
// Stall
//  - While a result waits on rsp_tready, req_tready is low; the result and
//    the RAM read data hold. A taken result frees the slot in the same cycle.
// Reset
//  - Synchronous. Clears counts, backlog pointers, fill and the cap. The
//    backlog RAM is not cleared: only written entries are ever read, so no
//    clearing pass is needed and the block is ready straight after reset.
`default_nettype none
module spawn_admission_throttle_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [sat_pkg::CAP_BITS-1:0]      csr_wr_data,
   // requests
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // tdata, from bit 0: from_own_worker, spawn_tag, zero pad
   input  wire logic [sat_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: req_type
   input  wire logic                              req_tuser,
   // results
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata, from bit 0: dispatch_valid, dispatch_tag, deferred, error_code,
   // live_now, resident_now, backlog_now, drained, zero pad
   output      logic [sat_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sat_pkg::*;

   // state
   cap_type   cap_ff;
   count_type live_ff, live_in;
   count_type res_ff, res_in;
   fill_type  fill_ff, fill_in;
   idx_type   head_ff, head_in;
   idx_type   tail_ff, tail_in;

   // result register
   logic         rsp_valid_ff;
   logic         dv_ff, dv_in;
   logic         pop_ff;
   logic         def_ff, def_in;
   err_code_type err_ff, err_in;
   tag_type      tag_ff;

   logic         accept;
   logic         push, pop;
   logic         own;
   tag_type      tag;
   req_kind_type kind;
   count_type    res_dec;
   tag_type      ram_q;
   tag_type      out_tag;

   function automatic logic cap_hit(input cap_type cap, input count_type res);
      cap_hit = (cap != '0) && (CMP_BITS'(res) >= CMP_BITS'(cap));
   endfunction

   function automatic count_type sat_inc(input count_type c);
      sat_inc = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign own        = req_tdata[0];
   assign tag        = req_tdata[TAG_BITS:1];
   assign kind       = req_kind_type'(req_tuser);

   always_comb begin
      live_in = live_ff;
      res_in  = res_ff;
      fill_in = fill_ff;
      res_dec = res_ff;
      push    = 1'b0;
      pop     = 1'b0;
      dv_in   = 1'b0;
      def_in  = 1'b0;
      err_in  = ERR_OK;
      if (accept) begin
         unique case (kind)
            REQ_SPAWN: begin
               priority if (live_ff == COUNT_MAX) begin
                  err_in = ERR_LIVE_OVERFLOW;
               end else if (own || (fill_ff == '0 && !cap_hit(cap_ff, res_ff))) begin
                  live_in = live_ff + COUNT_BITS'(1);
                  res_in  = sat_inc(res_ff);
                  dv_in   = 1'b1;
               end else if (fill_ff == FILL_BITS'(BACKLOG_DEPTH)) begin
                  err_in = ERR_BACKLOG_FULL;
               end else begin
                  // backlog non-empty or cap reached; the head may still go if the
                  // cap was raised, and it is never the entry pushed now
                  live_in = live_ff + COUNT_BITS'(1);
                  push    = 1'b1;
                  def_in  = 1'b1;
                  pop     = !cap_hit(cap_ff, res_ff);
                  dv_in   = pop;
                  res_in  = pop ? sat_inc(res_ff) : res_ff;
                  fill_in = pop ? fill_ff : fill_ff + FILL_BITS'(1);
               end
            end
            REQ_COMPLETE: begin
               if (live_ff == '0) begin
                  err_in = ERR_NO_LIVE;
               end else begin
                  res_dec = (res_ff != '0) ? res_ff - COUNT_BITS'(1) : res_ff;
                  live_in = live_ff - COUNT_BITS'(1);
                  pop     = (fill_ff != '0) && !cap_hit(cap_ff, res_dec);
                  dv_in   = pop;
                  res_in  = pop ? sat_inc(res_dec) : res_dec;
                  fill_in = pop ? fill_ff - FILL_BITS'(1) : fill_ff;
               end
            end
            default: ;
         endcase
      end
      head_in = pop  ? next_idx(head_ff) : head_ff;
      tail_in = push ? next_idx(tail_ff) : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         live_ff      <= '0;
         res_ff       <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         live_ff <= live_in;
         res_ff  <= res_in;
         fill_ff <= fill_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         dv_ff  <= dv_in;
         pop_ff <= pop;
         def_ff <= def_in;
         err_ff <= err_in;
         tag_ff <= tag;
      end
   end

   // backlog store: push at tail, head read lands with the result register
   sat_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (BACKLOG_DEPTH)
   ) u_backlog (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (tag),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (ram_q)
   );

   assign out_tag    = dv_ff ? (pop_ff ? ram_q : tag_ff) : '0;
   assign rsp_tvalid = rsp_valid_ff;
   // counts are the live state registers: they hold the post-event values
   // until the next transaction is taken
   assign rsp_tdata  = RSP_DATA_BITS'({(live_ff == '0), fill_ff, res_ff, live_ff,
                                       err_ff, def_ff, out_tag, dv_ff});

endmodule
`default_nettype wire

// ===== src/sat_checker.sv =====
// Port-level checker for the spawn admission throttle, bound to the top level.
`default_nettype none
module sat_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [sat_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sat_pkg::*;

   logic dv, def, drn;
   logic [1:0] err;
   tag_type    dtag;
   count_type  live;
   fill_type   fill;

   assign dv   = rsp_tdata[RSP_DV_POS];
   assign def  = rsp_tdata[RSP_DEF_POS];
   assign drn  = rsp_tdata[RSP_DRN_POS];
   assign err  = rsp_tdata[RSP_ERR_LSB +: 2];
   assign dtag = rsp_tdata[RSP_TAG_LSB +: TAG_BITS];
   assign live = rsp_tdata[RSP_LIVE_LSB +: COUNT_BITS];
   assign fill = rsp_tdata[RSP_FILL_LSB +: FILL_BITS];

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (drn == (live == '0)))
      else $error("drained flag disagrees with live count");

   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (err != ERR_OK) |-> !dv && !def)
      else $error("errored transaction dispatched or deferred");

   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !dv |-> (dtag == '0))
      else $error("tag present without dispatch");

   a_def_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && def |-> (fill != '0))
      else $error("deferred with empty backlog");

endmodule

bind spawn_admission_throttle_unit sat_checker u_sat_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
